// ----- rtl/tsp_elb_pkg.sv -----
// Shared types and constants for the TSP two-minimum-edge lower bound block.
// Used by tsp_elb_row, tsp_elb_acc and tsp_edge_lower_bound.
`timescale 1ns / 1ps
package tsp_elb_pkg;

   localparam int NodeW      = 4;
   localparam int CountW     = 5;
   localparam int WeightW    = 16;
   localparam int EdgeW      = WeightW + 1;
   localparam int DecisionW  = 2;
   localparam int SumW       = 22;
   localparam int BoundW     = 21;
   localparam int ReqDataW   = 32;
   localparam int RspDataW   = 24;
   localparam int DefMaxNodeCount = 16;
   localparam int FieldMaxNodes   = 16;
   localparam int MinNodes        = 3;

   localparam logic [CountW-1:0]    CountReset = 5'd11;
   localparam logic [EdgeW-1:0]     EdgeEmpty  = 17'h10000;
   localparam logic [BoundW-1:0]    BoundMax   = 21'h1FFFFF;

   localparam logic [DecisionW-1:0] DecInclude   = 2'd0;
   localparam logic [DecisionW-1:0] DecUndecided = 2'd2;

   typedef struct packed {
      logic [EdgeW-1:0] term_a;
      logic [EdgeW-1:0] term_b;
      logic             forced_over;
      logic             matrix_end;
   } row_sum_type;

endpackage

// ----- rtl/tsp_elb_row.sv -----
// Per-row edge tracking: first two forced edges and two cheapest open edges.
// Emits a registered row summary on each row end. Depends on tsp_elb_pkg.
`timescale 1ns / 1ps
module tsp_elb_row
   import tsp_elb_pkg::*;
#(
   parameter int MAX_NODE_COUNT = DefMaxNodeCount
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_take,
   input  logic                 sum_take,
   input  logic [CountW-1:0]    node_count,
   input  logic [NodeW-1:0]     row_node,
   input  logic [NodeW-1:0]     column_node,
   input  logic [WeightW-1:0]   edge_weight,
   input  logic [DecisionW-1:0] edge_decision,
   output row_sum_type          row_sum,
   output logic                 row_sum_valid
);

   localparam int CapNodes = (MAX_NODE_COUNT < FieldMaxNodes) ? MAX_NODE_COUNT
                                                               : FieldMaxNodes;
   localparam logic [CountW-1:0] CapCount = CountW'(CapNodes);
   localparam logic [CountW-1:0] MinCount = CountW'(MinNodes);

   logic [EdgeW-1:0] first_forced_ff, first_forced_in;
   logic [EdgeW-1:0] second_forced_ff, second_forced_in;
   logic [EdgeW-1:0] cheapest_open_ff, cheapest_open_in;
   logic [EdgeW-1:0] second_open_ff, second_open_in;
   logic             forced_over_ff, forced_over_in;
   row_sum_type      row_sum_ff, row_sum_in;
   logic             row_sum_valid_ff, row_sum_valid_in;

   logic [CountW-1:0] eff_nodes;
   logic [NodeW-1:0]  last_node;
   logic              in_range;
   logic              row_end;
   logic [EdgeW-1:0]  weight_ext;
   logic [EdgeW-1:0]  ff1, ff2, op1, op2;
   logic              over;

   always_comb begin
      if (node_count < MinCount) begin
         eff_nodes = MinCount;
      end else if (node_count > CapCount) begin
         eff_nodes = CapCount;
      end else begin
         eff_nodes = node_count;
      end
   end

   assign last_node  = NodeW'(eff_nodes - CountW'(1));
   assign in_range   = ({1'b0, row_node} < eff_nodes) && ({1'b0, column_node} < eff_nodes);
   assign row_end    = in_range && (column_node == last_node);
   assign weight_ext = {1'b0, edge_weight};

   always_comb begin
      ff1  = first_forced_ff;
      ff2  = second_forced_ff;
      op1  = cheapest_open_ff;
      op2  = second_open_ff;
      over = forced_over_ff;
      if (in_range && (row_node != column_node)) begin
         if (edge_decision == DecInclude) begin
            if (first_forced_ff == EdgeEmpty) begin
               ff1 = weight_ext;
            end else if (second_forced_ff == EdgeEmpty) begin
               ff2 = weight_ext;
            end else begin
               over = 1'b1;
            end
         end else if (edge_decision == DecUndecided) begin
            if (weight_ext < cheapest_open_ff) begin
               op2 = cheapest_open_ff;
               op1 = weight_ext;
            end else if (weight_ext < second_open_ff) begin
               op2 = weight_ext;
            end
         end
      end
   end

   always_comb begin
      first_forced_in  = first_forced_ff;
      second_forced_in = second_forced_ff;
      cheapest_open_in = cheapest_open_ff;
      second_open_in   = second_open_ff;
      forced_over_in   = forced_over_ff;
      row_sum_in       = row_sum_ff;
      row_sum_valid_in = row_sum_valid_ff;
      if (sum_take) begin
         row_sum_valid_in = 1'b0;
      end
      if (item_take) begin
         if (row_end) begin
            first_forced_in  = EdgeEmpty;
            second_forced_in = EdgeEmpty;
            cheapest_open_in = EdgeEmpty;
            second_open_in   = EdgeEmpty;
            forced_over_in   = 1'b0;
            row_sum_valid_in = 1'b1;
            row_sum_in.forced_over = over;
            row_sum_in.matrix_end  = (row_node == last_node);
            if ((ff1 != EdgeEmpty) && (ff2 != EdgeEmpty)) begin
               row_sum_in.term_a = ff1;
               row_sum_in.term_b = ff2;
            end else if (ff1 != EdgeEmpty) begin
               row_sum_in.term_a = ff1;
               row_sum_in.term_b = op1;
            end else begin
               row_sum_in.term_a = op1;
               row_sum_in.term_b = op2;
            end
         end else begin
            first_forced_in  = ff1;
            second_forced_in = ff2;
            cheapest_open_in = op1;
            second_open_in   = op2;
            forced_over_in   = over;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_forced_ff  <= EdgeEmpty;
         second_forced_ff <= EdgeEmpty;
         cheapest_open_ff <= EdgeEmpty;
         second_open_ff   <= EdgeEmpty;
         forced_over_ff   <= 1'b0;
         row_sum_valid_ff <= 1'b0;
      end else begin
         first_forced_ff  <= first_forced_in;
         second_forced_ff <= second_forced_in;
         cheapest_open_ff <= cheapest_open_in;
         second_open_ff   <= second_open_in;
         forced_over_ff   <= forced_over_in;
         row_sum_valid_ff <= row_sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_sum_ff <= row_sum_in;
   end

   assign row_sum       = row_sum_ff;
   assign row_sum_valid = row_sum_valid_ff;

endmodule

// ----- rtl/tsp_elb_acc.sv -----
// Running sum of row terms, anomaly flags and the result output register.
// Depends on tsp_elb_pkg.
`timescale 1ns / 1ps
module tsp_elb_acc
   import tsp_elb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  row_sum_type         row_sum,
   input  logic                row_sum_valid,
   output logic                stall,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata
);

   logic [SumW-1:0]     running_sum_ff, running_sum_in;
   logic                missing_ff, missing_in;
   logic                over_ff, over_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [RspDataW-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic            take;
   logic            a_empty, b_empty;
   logic [SumW-1:0] sum_next;
   logic [BoundW-1:0] bound;
   logic            missing_next, over_next;

   assign stall = row_sum_valid && row_sum.matrix_end && rsp_tvalid_ff && !rsp_tready;
   assign take  = row_sum_valid && !stall;

   assign a_empty  = row_sum.term_a[WeightW];
   assign b_empty  = row_sum.term_b[WeightW];
   assign sum_next = running_sum_ff
                   + (a_empty ? SumW'(0) : SumW'(row_sum.term_a[WeightW-1:0]))
                   + (b_empty ? SumW'(0) : SumW'(row_sum.term_b[WeightW-1:0]));
   assign missing_next = missing_ff || a_empty || b_empty;
   assign over_next    = over_ff || row_sum.forced_over;
   assign bound = (sum_next > SumW'(BoundMax)) ? BoundMax : sum_next[BoundW-1:0];

   always_comb begin
      running_sum_in = running_sum_ff;
      missing_in     = missing_ff;
      over_in        = over_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (take) begin
         if (row_sum.matrix_end) begin
            running_sum_in = '0;
            missing_in     = 1'b0;
            over_in        = 1'b0;
            rsp_tvalid_in  = 1'b1;
            rsp_tdata_in   = {1'b0, over_next, missing_next, bound};
         end else begin
            running_sum_in = sum_next;
            missing_in     = missing_next;
            over_in        = over_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
         missing_ff     <= 1'b0;
         over_ff        <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         running_sum_ff <= running_sum_in;
         missing_ff     <= missing_in;
         over_ff        <= over_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- rtl/tsp_edge_lower_bound.sv -----
// The result of a matrix-end beat is registered in the row summary register,
// then in the output register.
// Throughput: one matrix entry per cycle; the input stalls only while a new
// result waits behind an untaken one in the output register.
// Reset (synchronous, active high): node count 11, row edges empty, sum and
// flags clear, no result pending.
`timescale 1ns / 1ps
module tsp_edge_lower_bound
   import tsp_elb_pkg::*;
#(
   parameter int MAX_NODE_COUNT = DefMaxNodeCount
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // row_node[3:0], column_node[7:4], edge_weight[23:8], edge_decision[25:24]
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // bound_half_units[20:0], missing_edge[21], too_many_forced[22]
   output logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CountW-1:0]   csr_data
);

   logic [CountW-1:0] node_count_ff, node_count_in;
   row_sum_type       row_sum;
   logic              row_sum_valid;
   logic              stall;
   logic              item_take;

   assign csr_ready     = 1'b1;
   assign node_count_in = csr_valid ? csr_data : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CountReset;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   assign req_tready = !stall;
   assign item_take  = req_tvalid && req_tready;

   tsp_elb_row #(
      .MAX_NODE_COUNT(MAX_NODE_COUNT)
   ) u_row (
      .clock         (clock),
      .reset         (reset),
      .item_take     (item_take),
      .sum_take      (!stall),
      .node_count    (node_count_ff),
      .row_node      (req_tdata[3:0]),
      .column_node   (req_tdata[7:4]),
      .edge_weight   (req_tdata[23:8]),
      .edge_decision (req_tdata[25:24]),
      .row_sum       (row_sum),
      .row_sum_valid (row_sum_valid)
   );

   tsp_elb_acc u_acc (
      .clock         (clock),
      .reset         (reset),
      .row_sum       (row_sum),
      .row_sum_valid (row_sum_valid),
      .stall         (stall),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

// ----- bench/tsp_edge_lower_bound_tb.sv -----
`timescale 1ns / 1ps
// Testbench for tsp_edge_lower_bound: drives matrix entries, node count writes and result stalls,
// and checks each bound beat against a scoreboard that tracks the row edges itself.
// Depends on tsp_elb_pkg and the tsp_edge_lower_bound RTL.
module tsp_edge_lower_bound_tb;
   import tsp_elb_pkg::*;

   localparam int MaxNodes    = 16;
   localparam int IdleLimit   = 5000;
   localparam int DrainCycles = 8;
   localparam int ReportLimit = 10;

   localparam logic [DecisionW-1:0] DecExclude = 2'd1;
   localparam logic [DecisionW-1:0] DecSpare   = 2'd3;

   class bound_scoreboard;
      logic [CountW-1:0]   node_count;
      logic [EdgeW-1:0]    forced_a, forced_b, open_a, open_b;
      logic [SumW-1:0]     sum;
      logic                missing, overforced;
      logic [RspDataW-1:0] bound_q[$];
      int unsigned         mismatches;

      function new();
         node_count = CountReset;
         clear_row();
         sum        = '0;
         missing    = 1'b0;
         overforced = 1'b0;
         mismatches = 0;
      endfunction

      function void set_count(logic [CountW-1:0] value);
         node_count = value;
      endfunction

      function int unsigned nodes_in_use();
         int unsigned n;
         n = node_count;
         if (n < MinNodes) n = MinNodes;
         if (n > MaxNodes) n = MaxNodes;
         if (n > FieldMaxNodes) n = FieldMaxNodes;
         return n;
      endfunction

      function void clear_row();
         forced_a = EdgeEmpty;
         forced_b = EdgeEmpty;
         open_a   = EdgeEmpty;
         open_b   = EdgeEmpty;
      endfunction

      function void add_term(logic [EdgeW-1:0] w);
         if (w == EdgeEmpty) begin
            missing = 1'b1;
         end else begin
            sum = sum + w;
         end
      endfunction

      function void close_row();
         if (forced_a != EdgeEmpty && forced_b != EdgeEmpty) begin
            add_term(forced_a);
            add_term(forced_b);
         end else if (forced_a != EdgeEmpty) begin
            add_term(forced_a);
            add_term(open_a);
         end else begin
            add_term(open_a);
            add_term(open_b);
         end
         clear_row();
      endfunction

      function void note_beat(logic [ReqDataW-1:0] data);
         logic [NodeW-1:0]     row, col;
         logic [EdgeW-1:0]     w;
         logic [DecisionW-1:0] dec;
         logic [BoundW-1:0]    bound;
         int unsigned          n;
         row = data[3:0];
         col = data[7:4];
         w   = {1'b0, data[23:8]};
         dec = data[25:24];
         n   = nodes_in_use();
         if (row >= n || col >= n) return;
         if (row != col) begin
            if (dec == DecInclude) begin
               if (forced_a == EdgeEmpty) forced_a = w;
               else if (forced_b == EdgeEmpty) forced_b = w;
               else overforced = 1'b1;
            end else if (dec == DecUndecided) begin
               if (w < open_a) begin
                  open_b = open_a;
                  open_a = w;
               end else if (w < open_b) begin
                  open_b = w;
               end
            end
         end
         if (col != n - 1) return;
         close_row();
         if (row != n - 1) return;
         bound = (sum > BoundMax) ? BoundMax : sum[BoundW-1:0];
         bound_q.push_back({1'b0, overforced, missing, bound});
         sum        = '0;
         missing    = 1'b0;
         overforced = 1'b0;
      endfunction

      function void note_mismatch(string field, int unsigned want, int unsigned got);
         mismatches++;
         if (mismatches <= ReportLimit)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_beat(logic [RspDataW-1:0] data);
         logic [RspDataW-1:0] want;
         if (bound_q.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("%0t: result beat %h with no bound pending", $time, data);
            return;
         end
         want = bound_q.pop_front();
         if (data[20:0] != want[20:0]) note_mismatch("bound_half_units", want[20:0], data[20:0]);
         if (data[21] != want[21]) note_mismatch("missing_edge", want[21], data[21]);
         if (data[22] != want[22]) note_mismatch("too_many_forced", want[22], data[22]);
      endfunction

      function void close_run();
         if (bound_q.size() != 0) begin
            mismatches += bound_q.size();
            $display("%0d bound beats never arrived", bound_q.size());
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_valid;
   logic                csr_ready;
   logic [CountW-1:0]   csr_data;

   bound_scoreboard sb;
   int              send_idle_pct = 0;
   int              stall_pct     = 0;
   int unsigned     items_sent    = 0;
   int unsigned     idle_cycles   = 0;

   tsp_edge_lower_bound #(
      .MAX_NODE_COUNT(MaxNodes)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // check beats and guard against a hung block
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) sb.note_beat(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles == IdleLimit) begin
            $display("%0t: no beat moved for %0d cycles", $time, IdleLimit);
            $display("Mismatches found");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic logic [WeightW-1:0] pick_weight();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return WeightW'($urandom_range(15));
         default: return WeightW'($urandom);
      endcase
   endfunction

   function automatic logic [DecisionW-1:0] pick_decision();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 25) return DecInclude;
      if (roll < 45) return DecExclude;
      if (roll < 95) return DecUndecided;
      return DecSpare;
   endfunction

   task automatic send_entry(input int unsigned row, input int unsigned col,
                             input logic [WeightW-1:0] w, input logic [DecisionW-1:0] dec);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, dec, w, NodeW'(col), NodeW'(row)};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.bound_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_count(input logic [CountW-1:0] value);
      logic taken;
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      sb.set_count(value);
   endtask

   task automatic send_matrix(input int unsigned n);
      int unsigned style, r, c, reps;
      logic [WeightW-1:0] heavy;
      style = $urandom_range(99);
      if (style < 70 || style >= 90) begin
         // well formed; the broken flavor drops some entries but keeps the matrix end
         for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
               if (style >= 90 && $urandom_range(9) == 0 && !(r == n - 1 && c == n - 1))
                  continue;
               send_entry(r, c, pick_weight(), pick_decision());
            end
         end
      end else if (style < 80) begin
         // pile up costly rows to push the sum past saturation and wrap
         reps = $urandom_range(40, 8);
         repeat (reps) begin
            r = $urandom_range(n - 2);
            heavy = WeightW'($urandom_range(16'hFFFF, 16'hF000));
            send_entry(r, $urandom_range(n - 2), heavy,
                       $urandom_range(1) ? DecInclude : DecUndecided);
            send_entry(r, n - 1, heavy, $urandom_range(1) ? DecInclude : DecUndecided);
         end
         send_entry(n - 1, n - 1, pick_weight(), pick_decision());
      end else begin
         reps = $urandom_range(30, 5);
         repeat (reps) begin
            send_entry($urandom_range(15), $urandom_range(15), pick_weight(),
                       DecisionW'($urandom_range(3)));
         end
         send_entry(n - 1, n - 1, pick_weight(), pick_decision());
      end
   endtask

   task automatic run_phase(input bit rewrite, input logic [CountW-1:0] value,
                            input int send_pct, input int stall,
                            input int unsigned min_items);
      int unsigned start;
      if (rewrite) write_count(value);
      send_idle_pct = send_pct;
      stall_pct     = stall;
      start         = items_sent;
      do begin
         send_matrix(sb.nodes_in_use());
      end while (items_sent - start < min_items);
   endtask

   task automatic run_directed();
      // reset count of 11: rows close on column 10, the matrix on entry (10, 10)
      send_entry(0, 1, 16'hFFFF, DecInclude);
      send_entry(0, 2, 16'h0000, DecInclude);
      send_entry(0, 3, 16'd9, DecUndecided);
      send_entry(0, 10, 16'h0000, DecExclude);
      send_entry(1, 0, 16'h0000, DecUndecided);
      send_entry(1, 1, 16'd5, DecInclude);
      send_entry(1, 10, 16'hFFFF, DecUndecided);
      send_entry(2, 0, 16'd7, DecInclude);
      send_entry(2, 3, 16'd3, DecUndecided);
      send_entry(2, 4, 16'd2, DecUndecided);
      send_entry(2, 10, 16'd1, DecExclude);
      send_entry(10, 10, 16'd4, DecUndecided);
      // third forced edge, out-of-range indexes, spare decision, missing terms
      send_entry(3, 0, 16'd10, DecInclude);
      send_entry(3, 1, 16'd20, DecInclude);
      send_entry(3, 2, 16'd30, DecInclude);
      send_entry(11, 10, 16'd5, DecUndecided);
      send_entry(3, 15, 16'd5, DecUndecided);
      send_entry(3, 5, 16'd40, DecSpare);
      send_entry(3, 10, 16'd50, DecExclude);
      send_entry(4, 10, 16'd60, DecInclude);
      send_entry(5, 6, 16'd8, DecUndecided);
      send_entry(5, 10, 16'd9, DecUndecided);
      send_entry(10, 9, 16'hFFFF, DecInclude);
      send_entry(10, 10, 16'h0000, DecUndecided);
   endtask

   initial begin
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_phase(1'b0, CountReset, 0, 0, 250);
      run_phase(1'b1, 5'd3, 64, 0, 250);
      run_phase(1'b1, 5'd16, 0, 64, 1);
      run_phase(1'b1, 5'd0, 15, 15, 200);
      run_phase(1'b1, 5'd31, 0, 0, 1);
      run_phase(1'b1, CountW'($urandom_range(15, 3)), 64, 0, 200);
      run_phase(1'b1, 5'd4, 0, 64, 150);
      run_phase(1'b1, CountW'($urandom_range(31)), 15, 15, 150);

      wait_idle();
      sb.close_run();
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
